[rtl/iso_tlp_pkg.sv]
// Shared types, constants and decode functions for the passive-target-list parser.
// Used by iso_tlp_parser, iso_tlp_format and iso14443a_target_list_parser.
`timescale 1ns / 1ps

package iso_tlp_pkg;

    // Fixed response limits
    localparam logic [1:0] TARGET_CAP    = 2'd2;
    localparam logic [7:0] MAX_UID_BYTES = 8'd10;
    localparam int         UID_SLOTS     = 10;
    localparam int         UID_W         = 8 * UID_SLOTS;

    // Port widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 136;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UID_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UID_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UID_LENGTH = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_RECORD     = 3'd0;
    localparam logic [2:0] ST_END_OK     = 3'd1;
    localparam logic [2:0] ST_TRUNC      = 3'd2;
    localparam logic [2:0] ST_BAD_LEN    = 3'd3;
    localparam logic [2:0] ST_NO_TARGETS = 3'd4;
    localparam logic [2:0] ERR_NONE      = 3'd0;

    // Card type codes
    localparam logic [2:0] CT_ULTRALIGHT = 3'd0;
    localparam logic [2:0] CT_CLASSIC1K  = 3'd1;
    localparam logic [2:0] CT_MINI       = 3'd2;
    localparam logic [2:0] CT_PLUS2K     = 3'd3;
    localparam logic [2:0] CT_CLASSIC4K  = 3'd4;
    localparam logic [2:0] CT_ISO_DEP    = 3'd5;

    // Parser phases, one-hot
    typedef enum logic [10:0] {
        PH_COUNT   = 11'b000_0000_0001,
        PH_TGNUM   = 11'b000_0000_0010,
        PH_ATQA_LO = 11'b000_0000_0100,
        PH_ATQA_HI = 11'b000_0000_1000,
        PH_SAK     = 11'b000_0001_0000,
        PH_UIDLEN  = 11'b000_0010_0000,
        PH_UID     = 11'b000_0100_0000,
        PH_ATSLEN  = 11'b000_1000_0000,
        PH_ATS     = 11'b001_0000_0000,
        PH_DONE    = 11'b010_0000_0000,
        PH_HOLD    = 11'b100_0000_0000
    } phase_t;

    // Wanted UID settings
    typedef struct packed {
        logic [63:0] uid_low;
        logic [15:0] uid_high;
        logic [3:0]  uid_len;
    } cfg_t;

    // Raw result from the parser, before card decode and UID compare
    typedef struct packed {
        logic             status;
        logic [2:0]       code;
        logic [7:0]       tgt_num;
        logic [15:0]      atqa;
        logic [7:0]       sak;
        logic [3:0]       uid_len;
        logic [UID_W-1:0] uid;
        logic             end_flag;
    } rec_t;

    // Formatted result item
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  tgt_num;
        logic [15:0] atqa;
        logic [7:0]  sak;
        logic [3:0]  uid_len;
        logic [63:0] uid_low;
        logic [15:0] uid_high;
        logic [2:0]  card_type;
        logic [8:0]  block_count;
        logic [4:0]  block_bytes;
        logic        uid_matches;
    } result_t;

    typedef struct packed {
        logic [2:0] card_type;
        logic [8:0] block_count;
        logic [4:0] block_bytes;
    } card_t;

    // An ATS follows the UID when bit 5 is set and the SAK is not one of
    // the dual-interface or bit-6 cases.
    function automatic logic sak_has_ats(input logic [7:0] s);
        return ((s & 8'h40) == 8'h00) && ((s & 8'h20) != 8'h00) &&
               ((s & 8'h28) != 8'h28) && ((s & 8'h30) != 8'h30);
    endfunction

    // Card type and memory layout from the low seven SAK bits.
    function automatic card_t decode_card(input logic [7:0] s);
        card_t c;
        case (s & 8'h7F)
            8'h00:         c = '{CT_ULTRALIGHT, 9'd16, 5'd4};
            8'h09:         c = '{CT_MINI, 9'd20, 5'd16};
            8'h10, 8'h11:  c = '{CT_PLUS2K, 9'd128, 5'd16};
            8'h18, 8'h38:  c = '{CT_CLASSIC4K, 9'd256, 5'd16};
            8'h20, 8'h24:  c = '{CT_ISO_DEP, 9'd0, 5'd1};
            default:       c = '{CT_CLASSIC1K, 9'd64, 5'd16};
        endcase
        return c;
    endfunction

endpackage

[rtl/iso_tlp_parser.sv]
// Byte-by-byte parser state for the passive-target-list response.
// Depends on iso_tlp_pkg; feeds raw records to iso_tlp_format.
`timescale 1ns / 1ps

module iso_tlp_parser
    import iso_tlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       last,
    output logic       emit,
    output rec_t       rec
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  targets_reg, targets_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  tn_reg, tn_next;
    logic [15:0] atqa_reg, atqa_next;
    logic [7:0]  sak_reg, sak_next;
    logic [3:0]  len_reg, len_next;
    logic [7:0]  uid_reg [UID_SLOTS];
    logic [7:0]  uid_next [UID_SLOTS];
    logic [2:0]  err_reg, err_next;
    logic        uid_done;
    logic        complete;

    // Next state and result for the byte at the input stage
    always_comb
    begin
        phase_next   = phase_reg;
        targets_next = targets_reg;
        cnt_next     = cnt_reg;
        tn_next      = tn_reg;
        atqa_next    = atqa_reg;
        sak_next     = sak_reg;
        len_next     = len_reg;
        err_next     = err_reg;
        uid_next     = uid_reg;
        uid_done     = 1'b0;
        complete     = 1'b0;
        emit         = 1'b0;
        rec          = '0;

        case (phase_reg)
            PH_COUNT:
            begin
                if (data_byte == 8'd0)
                begin
                    err_next   = ST_NO_TARGETS;
                    phase_next = PH_HOLD;
                end
                else
                begin
                    targets_next = (data_byte > {6'd0, TARGET_CAP}) ? TARGET_CAP
                                                                     : data_byte[1:0];
                    phase_next   = PH_TGNUM;
                end
            end
            PH_TGNUM:
            begin
                tn_next    = data_byte;
                atqa_next  = '0;
                sak_next   = '0;
                len_next   = '0;
                for (int i = 0; i < UID_SLOTS; i++)
                begin
                    uid_next[i] = '0;
                end
                phase_next = PH_ATQA_LO;
            end
            PH_ATQA_LO:
            begin
                atqa_next  = {8'h00, data_byte};
                phase_next = PH_ATQA_HI;
            end
            PH_ATQA_HI:
            begin
                atqa_next  = {data_byte, atqa_reg[7:0]};
                phase_next = PH_SAK;
            end
            PH_SAK:
            begin
                sak_next   = data_byte;
                phase_next = PH_UIDLEN;
            end
            PH_UIDLEN:
            begin
                if (data_byte > MAX_UID_BYTES)
                begin
                    err_next   = ST_BAD_LEN;
                    phase_next = PH_HOLD;
                end
                else
                begin
                    len_next = data_byte[3:0];
                    cnt_next = '0;
                    if (data_byte == 8'd0)
                    begin
                        uid_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_UID;
                    end
                end
            end
            PH_UID:
            begin
                if (cnt_reg < 8'(UID_SLOTS))
                begin
                    uid_next[cnt_reg[3:0]] = data_byte;
                end
                cnt_next = cnt_reg + 8'd1;
                if (cnt_next >= {4'd0, len_reg})
                begin
                    uid_done = 1'b1;
                end
            end
            PH_ATSLEN:
            begin
                // The ATS length byte counts itself.
                if (data_byte == 8'd0)
                begin
                    err_next   = ST_BAD_LEN;
                    phase_next = PH_HOLD;
                end
                else if (data_byte == 8'd1)
                begin
                    complete = 1'b1;
                end
                else
                begin
                    cnt_next   = data_byte - 8'd1;
                    phase_next = PH_ATS;
                end
            end
            PH_ATS:
            begin
                cnt_next = cnt_reg - 8'd1;
                if (cnt_next == 8'd0)
                begin
                    complete = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // After the UID, either skip an ATS or close the entry
        if (uid_done)
        begin
            if (sak_has_ats(sak_reg))
            begin
                phase_next = PH_ATSLEN;
            end
            else
            begin
                complete = 1'b1;
            end
        end
        if (complete)
        begin
            targets_next = targets_reg - 2'd1;
            phase_next   = (targets_next != 2'd0) ? PH_TGNUM : PH_DONE;
        end

        // Record fields as they stand after this byte
        rec.tgt_num  = tn_next;
        rec.atqa     = atqa_next;
        rec.sak      = sak_next;
        rec.uid_len  = len_next;
        for (int i = 0; i < UID_SLOTS; i++)
        begin
            rec.uid[8*i +: 8] = uid_next[i];
        end
        rec.status = 1'b0;
        rec.code   = ST_RECORD;

        // The last byte always reports; an earlier error or truncation
        // replaces any record completing here.
        if (last)
        begin
            emit         = 1'b1;
            rec.end_flag = 1'b1;
            if (err_next != ERR_NONE)
            begin
                rec.status = 1'b1;
                rec.code   = err_next;
            end
            else if (phase_next == PH_DONE && complete)
            begin
                rec.status = 1'b0;
            end
            else if (phase_next == PH_DONE)
            begin
                rec.status = 1'b1;
                rec.code   = ST_END_OK;
            end
            else
            begin
                rec.status = 1'b1;
                rec.code   = ST_TRUNC;
            end
            phase_next   = PH_COUNT;
            targets_next = '0;
            cnt_next     = '0;
            err_next     = ERR_NONE;
        end
        else if (complete)
        begin
            emit = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_COUNT;
            targets_reg <= '0;
            cnt_reg     <= '0;
            err_reg     <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            targets_reg <= targets_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
        end
    end

    // Held entry fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tn_reg   <= '0;
            atqa_reg <= '0;
            sak_reg  <= '0;
            len_reg  <= '0;
            for (int i = 0; i < UID_SLOTS; i++)
            begin
                uid_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            tn_reg   <= tn_next;
            atqa_reg <= atqa_next;
            sak_reg  <= sak_next;
            len_reg  <= len_next;
            uid_reg  <= uid_next;
        end
    end

endmodule

[rtl/iso_tlp_format.sv]
// Turns a raw parser record into a result item: card decode and UID compare.
// Depends on iso_tlp_pkg; used by iso14443a_target_list_parser.
`timescale 1ns / 1ps

module iso_tlp_format
    import iso_tlp_pkg::*;
(
    input  rec_t    rec,
    input  cfg_t    cfg,
    output result_t res
);

    logic [UID_W-1:0] wanted;
    card_t            card;
    logic             match;

    assign wanted = {cfg.uid_high, cfg.uid_low};
    assign card   = decode_card(rec.sak);

    // Length must agree and every valid byte must be equal
    always_comb
    begin
        match = (rec.uid_len == cfg.uid_len);
        for (int i = 0; i < UID_SLOTS; i++)
        begin
            if ((4'(i) < rec.uid_len) && (rec.uid[8*i +: 8] != wanted[8*i +: 8]))
            begin
                match = 1'b0;
            end
        end
    end

    // Status-only items carry zeros in every record field
    always_comb
    begin
        res = '0;
        if (rec.status)
        begin
            res.status = rec.code;
        end
        else
        begin
            res.status      = ST_RECORD;
            res.tgt_num     = rec.tgt_num;
            res.atqa        = rec.atqa;
            res.sak         = rec.sak;
            res.uid_len     = rec.uid_len;
            res.uid_low     = rec.uid[63:0];
            res.uid_high    = rec.uid[UID_W-1:64];
            res.card_type   = card.card_type;
            res.block_count = card.block_count;
            res.block_bytes = card.block_bytes;
            res.uid_matches = match;
        end
    end

endmodule

[rtl/iso14443a_target_list_parser.sv]
// Top level of the passive-target-list parser: input stage, settings, result stage.
// Depends on iso_tlp_pkg, iso_tlp_parser and iso_tlp_format.
`timescale 1ns / 1ps

// The block takes one response byte per clock cycle while it is not stalled,
// and gives at most one result item per byte. An accepted byte sits in the
// input register, where the parser state and the record decode act on it,
// and its result item (if any) is loaded into the output register when the
// input stage advances, which raises m_tvalid. The result status travels on
// m_tuser. The only stall comes from the output register: while it holds an
// item that m_tready has not taken, the input stage holds too. Settings on the
// cfg port are taken at any time, always ready, and must only be changed
// while no response is in flight.
module iso14443a_target_list_parser
    import iso_tlp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // last
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] target number, [23:8] atqa, [31:24] sak, [35:32] uid length,
    // [99:36] uid_low, [115:100] uid_high, [118:116] card_type,
    // [127:119] block_count, [132:128] bytes per block, [133] uid_matches,
    // [135:134] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,   // [2:0] status
    output logic                 m_tlast,   // end_of_response
    // Settings write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    logic       emit;
    rec_t       rec;
    result_t    res;
    cfg_t       cfg_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    logic       out_last_reg;

    // Input stage moves on when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
    end

    // Wanted UID settings
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_UID_LOW:    cfg_reg.uid_low  <= cfg_data;
                CFG_UID_HIGH:   cfg_reg.uid_high <= cfg_data[15:0];
                CFG_UID_LENGTH: cfg_reg.uid_len  <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    iso_tlp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .emit      (emit),
        .rec       (rec)
    );

    iso_tlp_format u_format (
        .rec (rec),
        .cfg (cfg_reg),
        .res (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_res_reg  <= res;
            out_last_reg <= rec.end_flag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {2'd0, out_res_reg.uid_matches, out_res_reg.block_bytes,
                       out_res_reg.block_count, out_res_reg.card_type,
                       out_res_reg.uid_high, out_res_reg.uid_low,
                       out_res_reg.uid_len, out_res_reg.sak, out_res_reg.atqa,
                       out_res_reg.tgt_num};

    // A byte waiting in the input stage is never dropped while stalled.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input stage lost a byte while stalled");

    // Results that do not end a response are always target records.
    a_mid_record: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> out_res_reg.status == ST_RECORD)
        else $error("status-only result before the last byte");

    // Status-only results carry no card layout.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.status != ST_RECORD |->
            out_res_reg.block_bytes == 5'd0 && out_res_reg.uid_matches == 1'b0)
        else $error("status-only result with record fields set");

    // A full result slot that is not taken stays full.
    a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg)
        else $error("result dropped while stalled");

endmodule
